// ===== sv/ile_pkg.sv =====
`timescale 1ns / 1ps

package ile_pkg;

   // Fixed field widths of the request and response items
   localparam int POS_W    = 7;
   localparam int CMD_W    = 3;
   localparam int RVAL_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

   // What the latched command turns into once checked against the length
   typedef enum logic [1:0] {
      OP_READ_OK,
      OP_INSERT,
      OP_DELETE,
      OP_REJECT
   } op_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SHIFT,
      ST_FINISH
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take_req;
      logic rd_pos;
      logic load_idx;
      logic shift_step;
      logic finish;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_kind_type op_kind;
      logic        shift_done;
      logic        out_free;
   } dp_stat_type;

endpackage

// ===== sv/ile_ctrl.sv =====
`timescale 1ns / 1ps

module ile_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output ile_pkg::ctrl_cmd_type cmd,
   input  ile_pkg::dp_stat_type  stat
);
   import ile_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.op_kind)
               OP_READ_OK: begin
                  cmd.rd_pos = 1'b1;
                  state_in   = ST_READ;
               end
               OP_INSERT, OP_DELETE: begin
                  cmd.load_idx = 1'b1;
                  state_in     = ST_SHIFT;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/ile_dp.sv =====
`timescale 1ns / 1ps

module ile_dp #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ile_pkg::ctrl_cmd_type               cmd,
   output ile_pkg::dp_stat_type                stat,
   input  logic [ile_pkg::CMD_W-1:0]           req_type,
   input  logic [ile_pkg::POS_W-1:0]           req_position,
   input  logic signed [ile_pkg::RVAL_W-1:0]   req_item_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [ile_pkg::RVAL_W-1:0]   rsp_read_value,
   output logic [ile_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ile_pkg::LEN_W-1:0]           rsp_list_length
);
   import ile_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];

   // latched request
   logic [CMD_W-1:0]         cmd_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [RVAL_W-1:0] value_ff;

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [AW-1:0]            idx_ff;
   logic [AW-1:0]            idx_in;
   logic                     wr_pend_ff;
   logic                     wr_pend_in;
   logic [AW-1:0]            wr_addr_ff;
   logic [AW-1:0]            wr_addr_in;
   logic [VALUE_WIDTH-1:0]   mem_q_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RVAL_W-1:0]        rval_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic [LEN_W-1:0]         len_ff;

   logic [CMPW-1:0]          cnt_x;
   logic [CMPW-1:0]          pos_x;
   logic [CMPW-1:0]          tgt_x;
   logic [CMPW-1:0]          idx_x;
   logic                     full;
   op_kind_type              op_kind;
   logic [STATUS_W-1:0]      op_status;
   logic [RVAL_W-1:0]        rval_sel;
   logic [RVAL_W-1:0]        mem_q32;
   logic [VALUE_WIDTH-1:0]   wide_value;
   logic                     is_insert;
   logic                     more;
   logic                     shift_done;
   logic                     mem_re;
   logic [AW-1:0]            rd_addr;
   logic                     mem_we;
   logic [AW-1:0]            wr_addr;
   logic [VALUE_WIDTH-1:0]   wr_data;

   assign wide_value = VALUE_WIDTH'(value_ff);

   generate
      if (VALUE_WIDTH >= RVAL_W) begin : g_rd_trunc
         assign mem_q32 = mem_q_ff[RVAL_W-1:0];
      end else begin : g_rd_ext
         assign mem_q32 = RVAL_W'(mem_q_ff);
      end
   endgenerate

   assign cnt_x = CMPW'(count_ff);
   assign pos_x = CMPW'(pos_ff);
   assign idx_x = CMPW'(idx_ff);
   assign full  = (cnt_x == CMPW'(CAPACITY));

   // check the latched command against the current length
   always_comb begin
      op_kind   = OP_REJECT;
      op_status = STAT_BAD_INDEX;
      case (cmd_ff)
         CMD_READ: begin
            if (pos_x < cnt_x) begin
               op_kind   = OP_READ_OK;
               op_status = STAT_DONE;
            end
         end
         CMD_INS_HEAD, CMD_APPEND: begin
            if (full) begin
               op_status = STAT_FULL;
            end else begin
               op_kind   = OP_INSERT;
               op_status = STAT_DONE;
            end
         end
         CMD_INS_AT: begin
            if (pos_x > cnt_x) begin
               op_status = STAT_BAD_INDEX;
            end else if (full) begin
               op_status = STAT_FULL;
            end else begin
               op_kind   = OP_INSERT;
               op_status = STAT_DONE;
            end
         end
         CMD_DELETE: begin
            if (pos_x < cnt_x) begin
               op_kind   = OP_DELETE;
               op_status = STAT_DONE;
            end
         end
         default: begin
            op_kind   = OP_REJECT;
            op_status = STAT_BAD_INDEX;
         end
      endcase
   end

   assign is_insert = (op_kind == OP_INSERT);

   always_comb begin
      case (cmd_ff)
         CMD_INS_HEAD: tgt_x = '0;
         CMD_APPEND:   tgt_x = cnt_x;
         default:      tgt_x = pos_x;
      endcase
   end

   // shift sequencer: one entry moved per cycle, read, then written in the next cycle
   always_comb begin
      more       = is_insert ? (idx_x > tgt_x) : ((idx_x + CMPW'(1)) < cnt_x);
      mem_re     = 1'b0;
      rd_addr    = AW'(pos_ff);
      mem_we     = wr_pend_ff;
      wr_addr    = wr_addr_ff;
      wr_data    = mem_q_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      idx_in     = idx_ff;
      shift_done = 1'b0;

      if (cmd.rd_pos) begin
         mem_re = 1'b1;
      end

      if (cmd.load_idx) begin
         idx_in = is_insert ? AW'(count_ff) : AW'(pos_ff);
      end

      if (cmd.shift_step) begin
         if (more) begin
            mem_re     = 1'b1;
            rd_addr    = is_insert ? (idx_ff - 1'b1) : (idx_ff + 1'b1);
            wr_pend_in = 1'b1;
            wr_addr_in = idx_ff;
            idx_in     = is_insert ? (idx_ff - 1'b1) : (idx_ff + 1'b1);
         end else if (!wr_pend_ff) begin
            shift_done = 1'b1;
            if (is_insert) begin
               mem_we  = 1'b1;
               wr_addr = idx_ff;
               wr_data = wide_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // result selection
   always_comb begin
      rval_sel = '0;
      count_in = count_ff;
      case (op_kind)
         OP_READ_OK: rval_sel = mem_q32;
         OP_INSERT:  count_in = count_ff + 1'b1;
         OP_DELETE:  count_in = count_ff - 1'b1;
         default: begin
            if (cmd_ff == CMD_READ) begin
               rval_sel = '1;
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.finish) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
      if (cmd.take_req) begin
         cmd_ff   <= req_type;
         pos_ff   <= req_position;
         value_ff <= req_item_value;
      end
      if (cmd.finish) begin
         rval_ff   <= rval_sel;
         status_ff <= op_status;
         len_ff    <= LEN_W'(CMPW'(count_in));
      end
   end

   assign stat.op_kind    = op_kind;
   assign stat.shift_done = shift_done;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rval_ff;
   assign rsp_status      = status_ff;
   assign rsp_list_length = len_ff;

endmodule

// ===== sv/indexed_list_engine_top.sv =====
`timescale 1ns / 1ps

// Indexed list engine: an ordered list of signed values, up to CAPACITY
// entries, kept packed at the low addresses of a single-port-write,
// single-port-read memory (entry 0 is the head). One request item carries a
// command (read, insert at head, append at tail, insert before an index,
// delete at an index), and each request gives exactly one response item with
// the value read (-1 for a read at an invalid index, 0 for other commands),
// a status (done, index invalid, list full) and the list length after the
// command. Refused and unknown commands leave the list untouched. An insert or
// delete moves the entries behind the affected position one per cycle through
// the memory ports, so the worst case is an insert at the head of a list one
// short of full. Requests are taken one at a time; the response sits in an
// output register, so a new request is accepted while the previous response
// still waits to be taken, and a stalled response holds the next one back in
// its last cycle. No clearing pass is needed after reset: only entries below
// the length are ever read.

module indexed_list_engine_top #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ile_pkg::CMD_W-1:0]           req_type,
   input  logic [ile_pkg::POS_W-1:0]           req_position,
   input  logic signed [ile_pkg::RVAL_W-1:0]   req_item_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ile_pkg::RVAL_W-1:0]   rsp_read_value,
   output logic [ile_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ile_pkg::LEN_W-1:0]           rsp_list_length
);
   import ile_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // Sequence each item: latch, check, read or shift, then post the result
   ile_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (ctrl_cmd),
      .stat      (dp_stat)
   );

   // Hold the list store, the length and the response register
   ile_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_list_length (rsp_list_length)
   );

endmodule
